[rtl/jtwa_pkg.sv]
// Shared types and constants for the jump-triggered window averager.
package jtwa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_CUTOUT  = 32;
  localparam int DEPTH       = MAX_CUTOUT + 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int DIVC_W      = $clog2(SUM_W + 1);
  localparam int GATE_W      = 16;
  localparam int CUTOUT_W    = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int USER_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GATE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUTOUT = CFG_IDX_W'(1);

  localparam logic [GATE_W-1:0]   GATE_RESET   = GATE_W'(1000);
  localparam logic [CUTOUT_W-1:0] CUTOUT_RESET = CUTOUT_W'(8);

  typedef enum logic [1:0] {
    SEL_RAW,
    SEL_MEAN,
    SEL_FLUSH
  } out_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     store;
    logic     div_start;
    logic     pos_clr;
    logic     pos_inc;
    logic     mem_rd;
    logic     emit;
    out_sel_t sel;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic capturing;
    logic jump;
    logic last;
    logic out_free;
    logic complete;
    logic div_done;
    logic mean_last;
    logic flush_last;
  } sts_t;

endpackage

[rtl/jtwa_div.sv]
// Bit-serial signed divider for the window mean, truncating toward zero.
module jtwa_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [jtwa_pkg::SUM_W-1:0]    dividend,
  input  logic        [jtwa_pkg::CNT_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [jtwa_pkg::SUM_W-1:0]    quotient
);

  logic                              busy;
  logic [jtwa_pkg::DIVC_W-1:0]       steps;
  logic [jtwa_pkg::SUM_W-1:0]        dq;
  logic [jtwa_pkg::CNT_W-1:0]        rem;
  logic [jtwa_pkg::CNT_W-1:0]        dvs;
  logic                              neg;
  logic [jtwa_pkg::CNT_W:0]          rem_shift;
  logic [jtwa_pkg::CNT_W:0]          trial;
  logic [jtwa_pkg::SUM_W-1:0]        mag;

  assign mag       = dividend[jtwa_pkg::SUM_W-1] ? jtwa_pkg::SUM_W'(-dividend)
                                                 : jtwa_pkg::SUM_W'(dividend);
  assign rem_shift = {rem, dq[jtwa_pkg::SUM_W-1]};
  assign trial     = rem_shift - {1'b0, dvs};
  assign quotient  = neg ? -$signed(dq) : $signed(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= jtwa_pkg::DIVC_W'(jtwa_pkg::SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == jtwa_pkg::DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[jtwa_pkg::SUM_W-1];
    end else if (busy) begin
      if (!trial[jtwa_pkg::CNT_W]) begin
        rem <= trial[jtwa_pkg::CNT_W-1:0];
        dq  <= {dq[jtwa_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[jtwa_pkg::CNT_W-1:0];
        dq  <= {dq[jtwa_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/jtwa_dp.sv]
// Datapath: config registers, jump detect, window store, sum, divider, output register.
module jtwa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [jtwa_pkg::SAMPLE_BITS-1:0]    s_tdata,   // sample_in
  input  logic                                s_tlast,   // stream_last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jtwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jtwa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [jtwa_pkg::SAMPLE_BITS-1:0]    m_tdata,   // sample_out
  output logic                                m_tlast,   // stream_end
  output logic [jtwa_pkg::USER_W-1:0]         m_tuser,   // replaced, run_last
  input  jtwa_pkg::cmd_t                      cmd,
  output jtwa_pkg::sts_t                      sts
);

  logic [jtwa_pkg::GATE_W-1:0]               gate;
  logic [jtwa_pkg::CUTOUT_W-1:0]             cutout;
  logic signed [jtwa_pkg::SAMPLE_BITS-1:0]   x_r;
  logic                                      last_r;
  logic signed [jtwa_pkg::SAMPLE_BITS-1:0]   prev;
  logic                                      have_prev;
  logic                                      capturing;
  logic [jtwa_pkg::CNT_W-1:0]                count;
  logic signed [jtwa_pkg::SUM_W-1:0]         sum;
  logic [jtwa_pkg::CNT_W-1:0]                pos;
  logic [jtwa_pkg::SAMPLE_BITS-1:0]          mem [jtwa_pkg::DEPTH];
  logic [jtwa_pkg::SAMPLE_BITS-1:0]          rdata;
  logic                                      out_valid;
  logic [jtwa_pkg::SAMPLE_BITS-1:0]          out_data;
  logic                                      out_last;
  logic [jtwa_pkg::USER_W-1:0]               out_user;

  logic [jtwa_pkg::CUTOUT_W-1:0]             eff;
  logic [jtwa_pkg::CNT_W-1:0]                need;
  logic signed [jtwa_pkg::SAMPLE_BITS:0]     diff;
  logic [jtwa_pkg::SAMPLE_BITS:0]            mag;
  logic [jtwa_pkg::CNT_W-1:0]                base_cnt;
  logic signed [jtwa_pkg::SUM_W-1:0]         base_sum;
  logic                                      div_done;
  logic signed [jtwa_pkg::SUM_W-1:0]         quot;
  logic [jtwa_pkg::CNT_W:0]                  pos_ext;
  logic [jtwa_pkg::CNT_W:0]                  cnt_ext;

  jtwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (cutout == '0) begin
      eff = jtwa_pkg::CUTOUT_W'(1);
    end else if (cutout > jtwa_pkg::CUTOUT_W'(jtwa_pkg::MAX_CUTOUT)) begin
      eff = jtwa_pkg::CUTOUT_W'(jtwa_pkg::MAX_CUTOUT);
    end else begin
      eff = cutout;
    end
  end

  assign need     = jtwa_pkg::CNT_W'(eff) + 1'b1;
  assign diff     = (jtwa_pkg::SAMPLE_BITS+1)'(x_r) - (jtwa_pkg::SAMPLE_BITS+1)'(prev);
  assign mag      = diff[jtwa_pkg::SAMPLE_BITS] ? (jtwa_pkg::SAMPLE_BITS+1)'(-diff)
                                                : (jtwa_pkg::SAMPLE_BITS+1)'(diff);
  assign base_cnt = capturing ? count : '0;
  assign base_sum = capturing ? sum : '0;
  assign pos_ext  = {1'b0, pos};
  assign cnt_ext  = {1'b0, count};

  assign sts.capturing  = capturing;
  assign sts.jump       = have_prev && (mag > (jtwa_pkg::SAMPLE_BITS+1)'(gate));
  assign sts.last       = last_r;
  assign sts.out_free   = !out_valid || m_tready;
  assign sts.complete   = (count >= need) || (count == jtwa_pkg::CNT_W'(jtwa_pkg::DEPTH));
  assign sts.div_done   = div_done;
  assign sts.mean_last  = (pos_ext + 2'd2) == cnt_ext;
  assign sts.flush_last = (pos_ext + 1'b1) == cnt_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate   <= jtwa_pkg::GATE_RESET;
      cutout <= jtwa_pkg::CUTOUT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == jtwa_pkg::REG_GATE) begin
        gate <= cfg_data[jtwa_pkg::GATE_W-1:0];
      end else if (cfg_index == jtwa_pkg::REG_CUTOUT) begin
        cutout <= cfg_data[jtwa_pkg::CUTOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= s_tdata;
      last_r <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      have_prev <= 1'b0;
      capturing <= 1'b0;
      count     <= '0;
      sum       <= '0;
    end else if (cmd.finish) begin
      prev      <= x_r;
      have_prev <= !last_r;
      capturing <= 1'b0;
      count     <= '0;
      sum       <= '0;
    end else if (cmd.store) begin
      capturing <= 1'b1;
      count     <= base_cnt + 1'b1;
      sum       <= base_sum + jtwa_pkg::SUM_W'(x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[base_cnt[jtwa_pkg::ADDR_W-1:0]] <= x_r;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[pos[jtwa_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // tuser: bit 0 replaced, bit 1 run_last
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.sel)
        jtwa_pkg::SEL_MEAN: begin
          out_data <= quot[jtwa_pkg::SAMPLE_BITS-1:0];
          out_last <= 1'b0;
          out_user <= 2'b01;
        end
        jtwa_pkg::SEL_FLUSH: begin
          out_data <= rdata;
          out_last <= sts.flush_last;
          out_user <= {sts.flush_last, 1'b0};
        end
        default: begin
          out_data <= x_r;
          out_last <= last_r;
          out_user <= 2'b10;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign m_tuser  = out_user;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("item loaded over an untaken result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= jtwa_pkg::CNT_W'(jtwa_pkg::DEPTH))
    else $error("window count past store depth");

  a_div_window: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (count >= jtwa_pkg::CNT_W'(2)))
    else $error("mean started on a window shorter than two");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !capturing |-> (count == '0))
    else $error("window count held outside a capture");

  a_mean_not_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> !m_tlast)
    else $error("replaced item marked as stream end");

endmodule

[rtl/jtwa_ctrl.sv]
// Controller state machine sequencing pass-through, capture, mean and flush.
module jtwa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  jtwa_pkg::sts_t sts,
  output jtwa_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_MEAN  = 8'b0001_0000,
    S_TAIL  = 8'b0010_0000,
    S_FRD   = 8'b0100_0000,
    S_FWR   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = jtwa_pkg::SEL_RAW;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.capturing || sts.jump) begin
          cmd.store  = 1'b1;
          state_next = S_CHECK;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts.complete) begin
          cmd.div_start = 1'b1;
          cmd.pos_clr   = 1'b1;
          state_next    = S_DIV;
        end else if (sts.last) begin
          cmd.pos_clr = 1'b1;
          state_next  = S_FRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = jtwa_pkg::SEL_MEAN;
          cmd.pos_inc = 1'b1;
          if (sts.mean_last) begin
            state_next = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_FWR;
      end
      S_FWR: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = jtwa_pkg::SEL_FLUSH;
          if (sts.flush_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
            state_next  = S_FRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/jump_triggered_window_averager.sv]
// Top level of the jump-triggered window averager.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata = sample_in, tlast = stream_last
//  m_*      out  tvalid/tready      tdata = sample_out, tuser = {run_last, replaced},
//                                   tlast = stream_end
//  cfg_*    in   cfg_valid/ready    cfg_index (0 gate, 1 cutout), cfg_data
//
// Pass-through item: accept, then evaluate. Capture item without result: accept,
// evaluate, check. Window completion: check, serial divider (one quotient bit per
// cycle), then the result items. Flush, per item: store read, then output load.
// Synchronous reset; no clearing pass. cfg writes are always taken.
// A stalled output holds the output register; input is taken again once it drains.
module jump_triggered_window_averager (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [jtwa_pkg::SAMPLE_BITS-1:0]    s_tdata,   // sample_in
  input  logic                                s_tlast,   // stream_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [jtwa_pkg::SAMPLE_BITS-1:0]    m_tdata,   // sample_out
  output logic [jtwa_pkg::USER_W-1:0]         m_tuser,   // replaced, run_last
  output logic                                m_tlast,   // stream_end
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jtwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jtwa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  jtwa_pkg::cmd_t cmd;
  jtwa_pkg::sts_t sts;

  jtwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jtwa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[sim/jump_triggered_window_averager_test.sv]
// Testbench for the jump-triggered window averager: directed table, random streams, scoreboard.
`timescale 1ns / 1ps

module jump_triggered_window_averager_test;
  import jtwa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENTS = 14;
  localparam int SEG_ITEMS = 20;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   replaced;
    logic                   run_last;
    logic                   stream_end;
  } avg_out_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   last;
    logic                   typed;
    avg_out_t               want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [SAMPLE_BITS-1:0] s_tdata;   // sample_in
  logic s_tlast;                     // stream_last
  logic m_tvalid;
  logic m_tready;
  logic [SAMPLE_BITS-1:0] m_tdata;   // sample_out
  logic [USER_W-1:0] m_tuser;        // replaced, run_last
  logic m_tlast;                     // stream_end
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jump_triggered_window_averager dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // filter state mirrored in the testbench
  logic [GATE_W-1:0]   gate_q;
  logic [CUTOUT_W-1:0] cutout_q;
  logic signed [SAMPLE_BITS-1:0] last_passed;
  bit  prev_valid;
  bit  in_window;
  int  win_store [DEPTH];
  int  win_count;
  int  win_sum;

  avg_out_t filtered_due [$];
  avg_out_t mon_want;
  plan_row_t plan [$];

  int errors;
  int items_sent;
  int results_seen;
  int mean_items;
  int stream_ends;
  int cfg_writes;
  int windows_done;
  int tx_idle;
  int rx_idle;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic int active_cutout();
    if (cutout_q < 1) return 1;
    if (cutout_q > MAX_CUTOUT) return MAX_CUTOUT;
    return int'(cutout_q);
  endfunction

  function automatic void queue_out(input int v, input bit rep, input bit rl, input bit se);
    avg_out_t r;
    r.value = v[SAMPLE_BITS-1:0];
    r.replaced = rep;
    r.run_last = rl;
    r.stream_end = se;
    filtered_due = {filtered_due, r};
  endfunction

  function automatic void add_row(input plan_row_t r);
    plan = {plan, r};
  endfunction

  task automatic spike_filter_step(input logic signed [SAMPLE_BITS-1:0] x, input bit last);
    int need;
    int d;
    int mean;
    need = active_cutout() + 1;
    if (!in_window) begin
      d = int'(x) - int'(last_passed);
      if (d < 0) d = -d;
      if (prev_valid && d > int'(gate_q)) begin
        in_window = 1'b1;
        win_count = 0;
        win_sum = 0;
      end else begin
        queue_out(int'(x), 1'b0, 1'b1, last);
        last_passed = x;
        prev_valid = !last;
        return;
      end
    end
    if (win_count < DEPTH) begin
      win_store[win_count] = int'(x);
      win_count++;
      win_sum += int'(x);
    end
    if (win_count >= need || win_count >= DEPTH) begin
      mean = win_sum / win_count;
      for (int i = 0; i + 1 < win_count; i++) queue_out(mean, 1'b1, 1'b0, 1'b0);
      queue_out(int'(x), 1'b0, 1'b1, last);
      windows_done++;
      last_passed = x;
      prev_valid = !last;
      in_window = 1'b0;
      win_count = 0;
      win_sum = 0;
      return;
    end
    if (last) begin
      for (int i = 0; i < win_count; i++)
        queue_out(win_store[i], 1'b0, i + 1 == win_count, i + 1 == win_count);
      last_passed = x;
      prev_valid = 1'b0;
      in_window = 1'b0;
      win_count = 0;
      win_sum = 0;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input bit last,
                             input bit typed, input avg_out_t want);
    int n0;
    while ($urandom_range(99, 0) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n0 = filtered_due.size();
    spike_filter_step(x, last);
    if (typed) begin
      while (filtered_due.size() > n0) filtered_due.delete(filtered_due.size() - 1);
      filtered_due = {filtered_due, want};
    end
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GATE:   gate_q = val[GATE_W-1:0];
      REG_CUTOUT: cutout_q = val[CUTOUT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic plan_row_t smp(input int x, input bit last);
    plan_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.data = x[CFG_DATA_W-1:0];
    r.last = last;
    return r;
  endfunction

  function automatic plan_row_t smp_t(input int x, input bit last, input int v,
                                      input bit rep, input bit rl, input bit se);
    plan_row_t r;
    r = smp(x, last);
    r.typed = 1'b1;
    r.want.value = v[SAMPLE_BITS-1:0];
    r.want.replaced = rep;
    r.want.run_last = rl;
    r.want.stream_end = se;
    return r;
  endfunction

  function automatic plan_row_t cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  function automatic int clamp_sample(input int t);
    if (t > 32767) return 32767;
    if (t < -32768) return -32768;
    return t;
  endfunction

  // receiver: random ready, or one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) mean_items++;
      if (m_tlast) stream_ends++;
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("item %0d with no expectation: sample_out %0d",
                                  results_seen, $signed(m_tdata)));
      end else begin
        mon_want = filtered_due.pop_front();
        if (m_tdata !== mon_want.value)
          report_mismatch($sformatf("item %0d: sample_out %0d, want %0d", results_seen,
                                    $signed(m_tdata), $signed(mon_want.value)));
        if (m_tuser[0] !== mon_want.replaced)
          report_mismatch($sformatf("item %0d: replaced %b, want %b", results_seen,
                                    m_tuser[0], mon_want.replaced));
        if (m_tuser[1] !== mon_want.run_last)
          report_mismatch($sformatf("item %0d: run_last %b, want %b", results_seen,
                                    m_tuser[1], mon_want.run_last));
        if (m_tlast !== mon_want.stream_end)
          report_mismatch($sformatf("item %0d: stream_end %b, want %b", results_seen,
                                    m_tlast, mon_want.stream_end));
      end
    end
  end

  initial begin
    int lvl;
    int t;
    int mag;
    int k;
    logic [CFG_DATA_W-1:0] g;
    logic [CFG_DATA_W-1:0] c;
    avg_out_t none;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    none = '0;
    hold_request = 1'b0;
    tx_idle = 18;
    rx_idle = 56;
    gate_q = GATE_RESET;
    cutout_q = CUTOUT_RESET;
    last_passed = '0;
    prev_valid = 1'b0;
    in_window = 1'b0;
    win_count = 0;
    win_sum = 0;
    lvl = 0;

    // reset gate 1000, cutout 8
    add_row(smp_t(-32768, 1'b0, -32768, 1'b0, 1'b1, 1'b0));  // first sample passes
    add_row(smp_t(-31768, 1'b0, -31768, 1'b0, 1'b1, 1'b0));  // step equal to gate
    add_row(smp_t(32767, 1'b1, 32767, 1'b0, 1'b1, 1'b1));    // jump on last: flush
    add_row(smp_t(32767, 1'b0, 32767, 1'b0, 1'b1, 1'b0));    // new stream
    add_row(cfg(REG_CUTOUT, 1));
    add_row(smp(-32768, 1'b0));
    add_row(smp(100, 1'b0));
    add_row(cfg(REG_GATE, 0));
    add_row(smp_t(100, 1'b0, 100, 1'b0, 1'b1, 1'b0));
    add_row(smp(101, 1'b0));
    add_row(smp(-7, 1'b0));
    add_row(cfg(REG_CUTOUT, 0));                             // acts as one
    add_row(smp(-6, 1'b0));
    add_row(smp(-9, 1'b0));                                  // negative mean truncation
    add_row(cfg(REG_GATE, 16'hFFFF));
    add_row(smp_t(-32768, 1'b0, -32768, 1'b0, 1'b1, 1'b0));
    add_row(smp_t(32767, 1'b1, 32767, 1'b0, 1'b1, 1'b1));
    add_row(cfg(REG_UNUSED, 16'hFFFF));
    add_row(cfg(REG_CUTOUT, 16'hFFFF));                      // 63 acts as max
    add_row(cfg(REG_GATE, 10));
    add_row(smp_t(0, 1'b0, 0, 1'b0, 1'b1, 1'b0));
    add_row(smp(500, 1'b0));
    add_row(smp(501, 1'b1));                                 // flush two
    add_row(cfg(REG_CUTOUT, 4));
    add_row(smp_t(0, 1'b0, 0, 1'b0, 1'b1, 1'b0));
    add_row(smp(1000, 1'b0));
    add_row(smp(1001, 1'b0));
    add_row(cfg(REG_CUTOUT, 1));                             // shrink mid-window
    add_row(smp(1002, 1'b0));
    add_row(smp(32767, 1'b0));
    add_row(smp(-32768, 1'b1));                              // mean rounds to zero

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      settle();
      if (s < 5) begin
        tx_idle = 18;
        rx_idle = 56;
      end else if (s < 10) begin
        tx_idle = 56;
        rx_idle = 18;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      k = $urandom_range(9, 0);
      case (k)
        0: g = 16'h0000;
        1: g = 16'hFFFF;
        2: g = 16'($urandom);
        default: g = 16'($urandom_range(2000, 0));
      endcase
      k = $urandom_range(9, 0);
      case (k)
        0: c = 16'(0);
        1: c = 16'(MAX_CUTOUT);
        2: c = 16'($urandom_range(63, MAX_CUTOUT + 1));
        default: c = 16'($urandom_range(6, 1));
      endcase
      write_reg(REG_GATE, g);
      write_reg(REG_CUTOUT, c);
      if (s == 10) hold_request = 1'b1;
      for (int j = 0; j < SEG_ITEMS; j++) begin
        k = $urandom_range(99, 0);
        mag = $urandom_range(1, 0) ? 1 : -1;
        if (k < 12) begin
          t = int'($signed(16'($urandom)));
        end else if (k < 30) begin
          t = clamp_sample(lvl + mag * (int'(gate_q) + 1 + $urandom_range(3000, 0)));
        end else begin
          t = clamp_sample(lvl + mag * int'($urandom_range(int'(gate_q), 0)));
        end
        lvl = t;
        send_sample(t[SAMPLE_BITS-1:0], $urandom_range(29, 0) == 0, 1'b0, none);
      end
    end

    settle();
    repeat (60) @(posedge clk);

    $display("covered %0d input items, %0d result items, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("%0d windows averaged, %0d mean items, %0d stream ends, %0d errors",
             windows_done, mean_items, stream_ends, errors);
    if (errors == 0 && filtered_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[jump_triggered_window_averager.f]
rtl/jtwa_pkg.sv
rtl/jtwa_div.sv
rtl/jtwa_dp.sv
rtl/jtwa_ctrl.sv
rtl/jump_triggered_window_averager.sv
sim/jump_triggered_window_averager_test.sv
